@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/bcr_pkg.sv @@
// ----------------------------------------------------------------------------
// bcr_pkg
// Types, codes and constants of the circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

    localparam int COORD_W  = 10;
    localparam int CENTER_W = 11;
    localparam int PIX_W    = 12;
    localparam int DEC_W    = 14;
    localparam int CANVAS_W = 11;
    localparam int RAD_W    = 12;   // bits tried by the radius search
    localparam int MUL_W    = 24;   // shared multiplier operand width
    localparam int CFG_IDX_W = 2;

    localparam logic [CANVAS_W-1:0] CANVAS_RESET = 11'd500;
    localparam logic [DEC_W-1:0]    DEC_INIT     = 14'd3;
    localparam logic [DEC_W-1:0]    DEC_STEP_X   = 14'd6;
    localparam logic [DEC_W-1:0]    DEC_STEP_XY  = 14'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    // func codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [COORD_W-1:0]  corner_x;
        logic [COORD_W-1:0]  corner_y;
        logic [COORD_W-1:0]  box_width;
        logic [COORD_W-1:0]  box_height;
    } t_in_word;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    on_canvas;
        logic                    last;
        logic                    done_res;
    } t_out_word;

    typedef struct packed {
        logic             done;
        logic [RAD_W-1:0] radius;
    } t_rad_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RADIUS,
        ST_EMIT
    } t_top_state;

    typedef enum logic [2:0] {
        RS_IDLE,
        RS_WW,
        RS_HH,
        RS_WH,
        RS_PP,
        RS_SQ,
        RS_PRD,
        RS_CMP
    } t_rad_state;

endpackage

`default_nettype wire

@@ rtl/core/bresenham_circle_rasterizer.sv @@
// ----------------------------------------------------------------------------
// bresenham_circle_rasterizer
// Midpoint circle rasterizer: start words set up a circle in a box, step
// words advance it by one octant point, each run gives eight pixel words.
// ----------------------------------------------------------------------------
// A start word (func 0) takes the box corner and size, sets the center to
// corner plus half size and finds the inscribed radius; it then sends the
// eight mirror pixels of (0, r). A step word (func 1) runs one decision
// update and sends the eight mirror pixels of the new point; a step with no
// circle in progress sends nothing. Every pixel is flagged against the
// canvas size registers; last marks the eighth word of a run and done_res
// marks every word of the final run (a zero radius makes the start run
// final). Pixel words go out one per cycle through the output register, held
// while the output stalls. A start first runs the radius search on one
// shared 24x24 multiplier (four setup products, then the square, product and
// compare states for each radius bit over 12 bits), then hands the radius
// over and sends the 8 pixel words. A zero box stops the search after the
// four setup products. Input stall stays high from accept until the last
// pixel word is loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_circle_rasterizer (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input channel
    input  wire                            i_valid,
    input  wire  bcr_pkg::t_in_word        i_word,
    output logic                           o_stall,
    // output channel
    output logic                           o_valid,
    output bcr_pkg::t_out_word             o_word,
    input  wire                            i_stall,
    // configuration
    input  wire                            i_cfg_we,
    input  wire  [bcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [bcr_pkg::CANVAS_W-1:0]   i_cfg_data
);

    `include "assert_macros.svh"

    bcr_pkg::t_top_state r_state, n_state;

    // canvas registers
    logic [bcr_pkg::CANVAS_W-1:0] r_cw, r_ch;

    // circle state
    logic [bcr_pkg::CENTER_W-1:0] r_cc, r_cr;
    logic [bcr_pkg::COORD_W-1:0]  r_ox, r_oy;
    logic [bcr_pkg::DEC_W-1:0]    r_dec;
    logic                         r_drawing;
    logic                         r_done;
    // point of the current run, unwrapped
    logic signed [bcr_pkg::PIX_W-1:0] r_ex, r_ey;
    logic [2:0]                   r_k;

    // output register
    logic                         r_ovalid;
    bcr_pkg::t_out_word           r_out;

    logic                         in_acc;
    logic                         acc_start, acc_step;
    logic                         load;
    bcr_pkg::t_rad_res            rad_res;

    // step update
    logic [bcr_pkg::DEC_W-1:0]    x4, y4, n_dec;
    logic signed [bcr_pkg::PIX_W-1:0] n_x, n_y;
    logic                         n_done;

    // pixel build
    logic                         neg_c, neg_r, swap;
    logic signed [12:0]           cx13, cy13, a_c, a_r, px, py;
    logic                         on_c, on_r;
    bcr_pkg::t_out_word           pix;

    assign in_acc    = i_valid && !o_stall;
    assign acc_start = in_acc && (i_word.func == bcr_pkg::FUNC_START);
    assign acc_step  = in_acc && (i_word.func == bcr_pkg::FUNC_STEP) && r_drawing;
    assign load      = (r_state == bcr_pkg::ST_EMIT) && (!r_ovalid || !i_stall);

    bcr_radius u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (acc_start),
        .i_w     (i_word.box_width),
        .i_h     (i_word.box_height),
        .o_res   (rad_res)
    );

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        unique case (r_state)
            bcr_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (acc_start)     n_state = bcr_pkg::ST_RADIUS;
                else if (acc_step) n_state = bcr_pkg::ST_EMIT;
            end
            bcr_pkg::ST_RADIUS: begin
                if (rad_res.done) n_state = bcr_pkg::ST_EMIT;
            end
            bcr_pkg::ST_EMIT: begin
                if (load && (r_k == 3'd7)) n_state = bcr_pkg::ST_IDLE;
            end
            default: n_state = bcr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= bcr_pkg::CANVAS_RESET;
            r_ch <= bcr_pkg::CANVAS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bcr_pkg::CFG_CANVAS_WIDTH:  r_cw <= i_cfg_data;
                bcr_pkg::CFG_CANVAS_HEIGHT: r_ch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- decision update ----------------
    // d < 0: d += 4x + 6, x++;  else d += 4(x - y) + 10, x++, y--
    assign x4 = {2'b00, r_ox, 2'b00};
    assign y4 = {2'b00, r_oy, 2'b00};
    assign n_dec = r_dec[bcr_pkg::DEC_W-1] ? (r_dec + x4 + bcr_pkg::DEC_STEP_X)
                                           : (r_dec + x4 - y4 + bcr_pkg::DEC_STEP_XY);
    assign n_x = $signed({2'b00, r_ox}) + 12'sd1;
    assign n_y = r_dec[bcr_pkg::DEC_W-1] ? $signed({2'b00, r_oy})
                                         : $signed({2'b00, r_oy}) - 12'sd1;
    assign n_done = n_x > n_y;

    // circle state (reset to zero, idle)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc      <= '0;
            r_cr      <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_dec     <= '0;
            r_drawing <= 1'b0;
            r_done    <= 1'b0;
            r_ex      <= '0;
            r_ey      <= '0;
            r_k       <= '0;
        end else begin
            if (acc_start) begin
                r_cc <= {1'b0, i_word.corner_x} + {2'b00, i_word.box_width[9:1]};
                r_cr <= {1'b0, i_word.corner_y} + {2'b00, i_word.box_height[9:1]};
            end
            if ((r_state == bcr_pkg::ST_RADIUS) && rad_res.done) begin
                r_ox      <= '0;
                r_oy      <= rad_res.radius[bcr_pkg::COORD_W-1:0];
                r_dec     <= bcr_pkg::DEC_INIT -
                             {1'b0, rad_res.radius, 1'b0};
                r_drawing <= (rad_res.radius != '0);
                r_done    <= (rad_res.radius == '0);
                r_ex      <= '0;
                r_ey      <= $signed({2'b00, rad_res.radius[bcr_pkg::COORD_W-1:0]});
                r_k       <= '0;
            end else if (acc_step) begin
                r_ox      <= n_x[bcr_pkg::COORD_W-1:0];
                r_oy      <= n_y[bcr_pkg::COORD_W-1:0];
                r_dec     <= n_dec;
                r_drawing <= !n_done;
                r_done    <= n_done;
                r_ex      <= n_x;
                r_ey      <= n_y;
                r_k       <= '0;
            end else if (load) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    // ---------------- pixel build ----------------
    // run order: (+x,+y) (-x,+y) (+x,-y) (-x,-y) (+y,+x) (+y,-x) (-y,+x) (-y,-x)
    always_comb begin
        neg_c = 1'b0;
        neg_r = 1'b0;
        swap  = 1'b0;
        case (r_k)
            3'd0: begin neg_c = 1'b0; neg_r = 1'b0; swap = 1'b0; end
            3'd1: begin neg_c = 1'b1; neg_r = 1'b0; swap = 1'b0; end
            3'd2: begin neg_c = 1'b0; neg_r = 1'b1; swap = 1'b0; end
            3'd3: begin neg_c = 1'b1; neg_r = 1'b1; swap = 1'b0; end
            3'd4: begin neg_c = 1'b0; neg_r = 1'b0; swap = 1'b1; end
            3'd5: begin neg_c = 1'b0; neg_r = 1'b1; swap = 1'b1; end
            3'd6: begin neg_c = 1'b1; neg_r = 1'b0; swap = 1'b1; end
            default: begin neg_c = 1'b1; neg_r = 1'b1; swap = 1'b1; end
        endcase
    end

    assign cx13 = $signed({2'b00, r_cc});
    assign cy13 = $signed({2'b00, r_cr});
    assign a_c  = swap ? $signed({r_ey[bcr_pkg::PIX_W-1], r_ey})
                       : $signed({r_ex[bcr_pkg::PIX_W-1], r_ex});
    assign a_r  = swap ? $signed({r_ex[bcr_pkg::PIX_W-1], r_ex})
                       : $signed({r_ey[bcr_pkg::PIX_W-1], r_ey});
    assign px   = neg_c ? (cx13 - a_c) : (cx13 + a_c);
    assign py   = neg_r ? (cy13 - a_r) : (cy13 + a_r);
    // on-canvas judged on the unwrapped 13-bit coordinate
    assign on_c = !px[12] && (px[11:0] < {1'b0, r_cw});
    assign on_r = !py[12] && (py[11:0] < {1'b0, r_ch});

    always_comb begin
        pix.pixel_x   = px[bcr_pkg::PIX_W-1:0];
        pix.pixel_y   = py[bcr_pkg::PIX_W-1:0];
        pix.on_canvas = on_c && on_r;
        pix.last      = (r_k == 3'd7);
        pix.done_res  = r_done;
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= pix;
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_out;

    // ---------------- assertions ----------------
    // radius unit reports only while the top level waits for it
    `BCR_ASSERT_IMP(a_rad_done_in_radius, i_clk, i_rst_n,
                    rad_res.done, r_state == bcr_pkg::ST_RADIUS)
    // eighth pixel loaded ends the run
    `BCR_ASSERT_NXT(a_last_ends_run, i_clk, i_rst_n,
                    load && (r_k == 3'd7), r_state == bcr_pkg::ST_IDLE)
    // a circle still in progress never has x past y
    `BCR_ASSERT_IMP(a_drawing_octant, i_clk, i_rst_n,
                    r_drawing && (r_state == bcr_pkg::ST_IDLE), r_ex <= r_ey)

endmodule

`default_nettype wire

@@ rtl/core/bcr_radius.sv @@
// ----------------------------------------------------------------------------
// bcr_radius
// Radius search: largest r with 4*r*r*(w*w+h*h) <= (w*h)^2, one bit per
// pass, all products through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_radius (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [bcr_pkg::COORD_W-1:0]  i_w,
    input  wire  [bcr_pkg::COORD_W-1:0]  i_h,
    output bcr_pkg::t_rad_res            o_res
);

    bcr_pkg::t_rad_state r_state, n_state;

    logic [bcr_pkg::COORD_W-1:0] r_w, r_h;
    logic [2*bcr_pkg::MUL_W-1:0] r_prod;
    logic [20:0]                 r_s;      // w*w + h*h
    logic [39:0]                 r_p2;     // (w*h)^2
    logic [bcr_pkg::RAD_W-1:0]   r_r;
    logic [3:0]                  r_bit;
    logic                        r_done;

    logic [bcr_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [2*bcr_pkg::MUL_W-1:0] mul_out;
    logic [bcr_pkg::RAD_W-1:0]   cand;
    logic                        fits;
    logic                        p_zero;

    assign cand    = r_r | (bcr_pkg::RAD_W'(1) << r_bit);
    assign mul_out = mul_a * mul_b;
    assign fits    = {r_prod[45:0], 2'b00} <= {8'd0, r_p2};
    assign p_zero  = (r_prod[19:0] == 20'd0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            bcr_pkg::RS_WW: begin
                mul_a = bcr_pkg::MUL_W'(r_w);
                mul_b = bcr_pkg::MUL_W'(r_w);
            end
            bcr_pkg::RS_HH: begin
                mul_a = bcr_pkg::MUL_W'(r_h);
                mul_b = bcr_pkg::MUL_W'(r_h);
            end
            bcr_pkg::RS_WH: begin
                mul_a = bcr_pkg::MUL_W'(r_w);
                mul_b = bcr_pkg::MUL_W'(r_h);
            end
            bcr_pkg::RS_PP: begin
                mul_a = bcr_pkg::MUL_W'(r_prod[19:0]);
                mul_b = bcr_pkg::MUL_W'(r_prod[19:0]);
            end
            bcr_pkg::RS_SQ: begin
                mul_a = bcr_pkg::MUL_W'(cand);
                mul_b = bcr_pkg::MUL_W'(cand);
            end
            bcr_pkg::RS_PRD: begin
                mul_a = r_prod[bcr_pkg::MUL_W-1:0];
                mul_b = bcr_pkg::MUL_W'(r_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcr_pkg::RS_IDLE: if (i_start) n_state = bcr_pkg::RS_WW;
            bcr_pkg::RS_WW:   n_state = bcr_pkg::RS_HH;
            bcr_pkg::RS_HH:   n_state = bcr_pkg::RS_WH;
            bcr_pkg::RS_WH:   n_state = bcr_pkg::RS_PP;
            bcr_pkg::RS_PP:   n_state = p_zero ? bcr_pkg::RS_IDLE : bcr_pkg::RS_SQ;
            bcr_pkg::RS_SQ:   n_state = bcr_pkg::RS_PRD;
            bcr_pkg::RS_PRD:  n_state = bcr_pkg::RS_CMP;
            bcr_pkg::RS_CMP:  n_state = (r_bit == 4'd0) ? bcr_pkg::RS_IDLE : bcr_pkg::RS_SQ;
            default:          n_state = bcr_pkg::RS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcr_pkg::RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == bcr_pkg::RS_PP) && p_zero) ||
                       ((r_state == bcr_pkg::RS_CMP) && (r_bit == 4'd0));
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            bcr_pkg::RS_IDLE: begin
                if (i_start) begin
                    r_w   <= i_w;
                    r_h   <= i_h;
                    r_r   <= '0;
                    r_bit <= 4'(bcr_pkg::RAD_W - 1);
                end
            end
            bcr_pkg::RS_WW: r_prod <= mul_out;
            bcr_pkg::RS_HH: begin
                r_s    <= r_prod[20:0];
                r_prod <= mul_out;
            end
            bcr_pkg::RS_WH: begin
                r_s    <= r_s + r_prod[20:0];
                r_prod <= mul_out;
            end
            bcr_pkg::RS_PP:  r_p2   <= mul_out[39:0];
            bcr_pkg::RS_SQ:  r_prod <= mul_out;
            bcr_pkg::RS_PRD: r_prod <= mul_out;
            bcr_pkg::RS_CMP: begin
                if (fits) r_r <= cand;
                r_bit <= r_bit - 4'd1;
            end
            default: ;
        endcase
    end

    assign o_res.done   = r_done;
    assign o_res.radius = r_r;

endmodule

`default_nettype wire
